// File: hw/rtl/pair_sum_two_pointer_search_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pair-sum search block
// Shared helpers that wrap concurrent assertions on a clock and a reset.
// ----------------------------------------------------------------------------
`ifndef PAIR_SUM_TWO_POINTER_SEARCH_ASSERT_SVH
`define PAIR_SUM_TWO_POINTER_SEARCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSTP_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSTP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/pstp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstp_pkg
// Widths, types and helpers shared by the pair-sum search block.
// ----------------------------------------------------------------------------
package pstp_pkg;

   localparam int MAX_ENTRIES = 1024;
   localparam int VALUE_WIDTH = 32;
   localparam int ADDR_WIDTH  = $clog2(MAX_ENTRIES);
   localparam int COUNT_WIDTH = ADDR_WIDTH + 1;
   localparam int INDEX_WIDTH = 11;
   localparam int SUM_WIDTH   = VALUE_WIDTH + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_COMPARE
   } pstp_state_type;

   // Loader to search engine: store write port and search start.
   typedef struct packed {
      logic                   wr_en;
      logic [ADDR_WIDTH-1:0]  wr_addr;
      logic [VALUE_WIDTH-1:0] wr_data;
      logic                   start;
      logic [ADDR_WIDTH-1:0]  last_ptr;
      logic [VALUE_WIDTH-1:0] target;
   } pstp_ctrl_type;

   // Search engine to loader: status and the finished result.
   typedef struct packed {
      logic                   busy;
      logic                   done;
      logic                   found;
      logic [INDEX_WIDTH-1:0] first_index;
      logic [INDEX_WIDTH-1:0] second_index;
   } pstp_status_type;

   function automatic logic signed [SUM_WIDTH-1:0] widen(input logic [VALUE_WIDTH-1:0] v);
      widen = $signed({v[VALUE_WIDTH-1], v});
   endfunction

endpackage

// File: hw/rtl/pstp_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstp_engine
// Entry store and two-pointer search sequencer with one shared adder and
// comparator.
// ----------------------------------------------------------------------------
`include "pair_sum_two_pointer_search_assert.svh"

module pstp_engine
   import pstp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  pstp_ctrl_type   ctrl,
   output pstp_status_type status
);

   logic [VALUE_WIDTH-1:0] value_store_ff [MAX_ENTRIES];
   logic [VALUE_WIDTH-1:0] rd_lo_ff;
   logic [VALUE_WIDTH-1:0] rd_hi_ff;

   pstp_state_type        state_ff, state_in;
   logic [ADDR_WIDTH-1:0] lo_ff, lo_in;
   logic [ADDR_WIDTH-1:0] hi_ff, hi_in;
   logic [VALUE_WIDTH-1:0] target_ff, target_in;

   logic signed [SUM_WIDTH-1:0] sum;
   logic signed [SUM_WIDTH-1:0] target_wide;

   // Both pointers are read in the check cycle; the data is compared in the next.
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         value_store_ff[ctrl.wr_addr] <= ctrl.wr_data;
      end
      if (state_ff == ST_CHECK) begin
         rd_lo_ff <= value_store_ff[lo_ff];
         rd_hi_ff <= value_store_ff[hi_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lo_ff    <= '0;
         hi_ff    <= '0;
      end else begin
         state_ff <= state_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
      end
      target_ff <= target_in;
   end

   assign sum         = widen(rd_lo_ff) + widen(rd_hi_ff);
   assign target_wide = widen(target_ff);

   always_comb begin
      state_in            = state_ff;
      lo_in               = lo_ff;
      hi_in               = hi_ff;
      target_in           = target_ff;
      status.busy         = (state_ff != ST_IDLE);
      status.done         = 1'b0;
      status.found        = 1'b0;
      status.first_index  = INDEX_WIDTH'({1'b0, lo_ff} + COUNT_WIDTH'(1));
      status.second_index = INDEX_WIDTH'({1'b0, hi_ff} + COUNT_WIDTH'(1));

      case (state_ff)
         ST_IDLE: begin
            if (ctrl.start) begin
               lo_in     = '0;
               hi_in     = ctrl.last_ptr;
               target_in = ctrl.target;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (lo_ff < hi_ff) begin
               state_in = ST_COMPARE;
            end else begin
               // Pointers have met without a match.
               status.done = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_COMPARE: begin
            if (sum == target_wide) begin
               status.done  = 1'b1;
               status.found = 1'b1;
               state_in     = ST_IDLE;
            end else if (sum < target_wide) begin
               lo_in    = lo_ff + ADDR_WIDTH'(1);
               state_in = ST_CHECK;
            end else begin
               hi_in    = hi_ff - ADDR_WIDTH'(1);
               state_in = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `PSTP_ASSERT_NOW(a_compare_ordered, clock, reset, state_ff == ST_COMPARE, lo_ff < hi_ff, "compare with crossed pointers")
   `PSTP_ASSERT_NOW(a_start_when_idle, clock, reset, ctrl.start, state_ff == ST_IDLE, "search started while busy")
   `PSTP_ASSERT_NOW(a_found_in_compare, clock, reset, status.found, state_ff == ST_COMPARE && status.done, "found outside compare")

endmodule

// File: hw/rtl/pair_sum_two_pointer_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_sum_two_pointer_search
// Loads a sorted array word by word and searches it from both ends for a
// pair that adds up to the target, returning the pair's 1-based indices.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Word contents
// req_      in         tdata[31:0] element_value, tlast is_last
// rsp_      out        tdata[10:0] first_index, [21:11] second_index, tuser found
// csr_      in         csr_wdata target_sum, written when csr_wen is high
//
// A word without tlast is stored, unless the store is full, and the next can
// follow at once. After the last word the search alternates a check and a
// compare state for each pointer step, with the single adder and comparator
// working on the registered reads of the entry store's two ports.
// The result sits in an output register from the cycle after the search ends;
// the input stays stalled until the search is done and the result has been taken.
// Reset is synchronous; the entry store is not cleared.
//
`include "pair_sum_two_pointer_search_assert.svh"

module pair_sum_two_pointer_search
   import pstp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [VALUE_WIDTH-1:0] req_tdata,  // [31:0] element_value
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [23:0]            rsp_tdata,  // [10:0] first_index, [21:11] second_index
   output logic                   rsp_tuser,  // [0] found
   input  logic                   csr_wen,
   input  logic [VALUE_WIDTH-1:0] csr_wdata
);

   pstp_ctrl_type   ctrl;
   pstp_status_type status;

   logic [VALUE_WIDTH-1:0] target_ff, target_in;
   logic [COUNT_WIDTH-1:0] load_count_ff, load_count_in;
   logic [COUNT_WIDTH-1:0] count_next;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [INDEX_WIDTH-1:0] rsp_first_ff, rsp_second_ff;
   logic                   rsp_found_ff;
   logic                   accept;
   logic                   room;

   pstp_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .status (status)
   );

   assign req_tready = !status.busy && !rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign room       = (load_count_ff < COUNT_WIDTH'(MAX_ENTRIES));
   assign count_next = room ? load_count_ff + COUNT_WIDTH'(1) : load_count_ff;

   // Words past a full store are dropped, but a last word still starts the search.
   always_comb begin
      ctrl.wr_en    = accept && room;
      ctrl.wr_addr  = load_count_ff[ADDR_WIDTH-1:0];
      ctrl.wr_data  = req_tdata;
      ctrl.start    = accept && req_tlast;
      ctrl.last_ptr = ADDR_WIDTH'(count_next - COUNT_WIDTH'(1));
      ctrl.target   = target_ff;

      target_in     = csr_wen ? csr_wdata : target_ff;
      load_count_in = load_count_ff;
      if (accept) begin
         load_count_in = req_tlast ? '0 : count_next;
      end
      rsp_valid_in = rsp_valid_ff;
      if (status.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= '0;
         load_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         target_ff     <= target_in;
         load_count_ff <= load_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (status.done) begin
         rsp_found_ff  <= status.found;
         rsp_first_ff  <= status.found ? status.first_index : '0;
         rsp_second_ff <= status.found ? status.second_index : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_second_ff, rsp_first_ff};
   assign rsp_tuser  = rsp_found_ff;

   `PSTP_ASSERT_NEXT(a_done_shows, clock, reset, status.done, rsp_valid_ff, "result not registered")
   `PSTP_ASSERT_NOW(a_no_take_while_held, clock, reset, rsp_valid_ff, !req_tready, "input open while result held")
   `PSTP_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, load_count_ff <= COUNT_WIDTH'(MAX_ENTRIES), "load count overran")

endmodule
